### sv/rhh_pkg.sv
// Shared types, codes and constants of the Robin Hood hash table.
`default_nettype none
package rhh_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam int          KEY_BYTES  = 4;
  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] FIB_MULT   = 32'd2654435769;
  localparam logic [3:0]  SIZE_RESET = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_value;
    logic [10:0] probes;
    logic [10:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] hash;
  } q_item_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_FIB, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_RD, B_EVAL, B_SH_RD, B_SH_EVAL
  } back_state_t;

endpackage
`default_nettype wire

### sv/rhh_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/rhh_front.sv
// Front end: accepts a request, trims the key and hashes it into the queue.
`default_nettype none
module rhh_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  wire rhh_pkg::in_item_t in_item,
  input  wire                 q_full,
  output logic                q_push,
  output rhh_pkg::q_item_t    q_item,
  output logic                busy
);

  rhh_pkg::front_state_t state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] h_r, h_nxt;
  logic [2:0]  b_r, b_nxt;
  logic [31:0] canon;
  logic        stop_seen;
  logic [7:0]  cur_byte;
  logic [31:0] fnv_prod;
  logic [31:0] fib_prod;
  logic        hash_done;

  // Keep only the bytes ahead of the first zero byte.
  always_comb begin
    canon = '0;
    stop_seen = 1'b0;
    for (int b = 0; b < rhh_pkg::KEY_BYTES; b++) begin
      if (in_item.key[8*b +: 8] == 8'd0) begin
        stop_seen = 1'b1;
      end
      if (!stop_seen) begin
        canon[8*b +: 8] = in_item.key[8*b +: 8];
      end
    end
  end

  assign cur_byte  = key_r[{b_r[1:0], 3'b000} +: 8];
  assign hash_done = (b_r == 3'(rhh_pkg::KEY_BYTES)) || (cur_byte == 8'd0);
  assign fnv_prod  = (h_r ^ {24'd0, cur_byte}) * rhh_pkg::FNV_PRIME;
  assign fib_prod  = h_r * rhh_pkg::FIB_MULT;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhh_pkg::F_IDLE: if (accept) state_nxt = rhh_pkg::F_HASH;
      rhh_pkg::F_HASH: if (hash_done) state_nxt = rhh_pkg::F_FIB;
      rhh_pkg::F_FIB:  state_nxt = rhh_pkg::F_PUSH;
      rhh_pkg::F_PUSH: if (!q_full) state_nxt = rhh_pkg::F_IDLE;
      default:         state_nxt = rhh_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt = kind_r;
    key_nxt  = key_r;
    val_nxt  = val_r;
    h_nxt    = h_r;
    b_nxt    = b_r;
    q_push   = 1'b0;
    unique case (state_r)
      rhh_pkg::F_IDLE: begin
        if (accept) begin
          kind_nxt = in_item.kind;
          key_nxt  = canon;
          val_nxt  = in_item.value;
          h_nxt    = rhh_pkg::FNV_BASIS;
          b_nxt    = 3'd0;
        end
      end
      rhh_pkg::F_HASH: begin
        if (!hash_done) begin
          h_nxt = fnv_prod;
          b_nxt = b_r + 3'd1;
        end
      end
      rhh_pkg::F_FIB:  h_nxt = fib_prod;
      rhh_pkg::F_PUSH: q_push = !q_full;
      default: ;
    endcase
  end

  assign q_item = '{kind: kind_r, key: key_r, value: val_r, hash: h_r};
  assign busy   = (state_r != rhh_pkg::F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhh_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    h_r    <= h_nxt;
    b_r    <= b_nxt;
  end

endmodule
`default_nettype wire

### sv/rhh_queue.sv
// Two-entry queue of hashed requests between the front and back ends.
`default_nettype none
module rhh_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  wire rhh_pkg::q_item_t push_item,
  output logic              full,
  input  wire               pop,
  output rhh_pkg::q_item_t  pop_item,
  output logic              empty
);

  rhh_pkg::q_item_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### sv/rhh_back.sv
// Back end: walks the probe chain in the slot RAM for insert, lookup and remove.
`default_nettype none
module rhh_back #(
  parameter int MAX_SLOTS_LOG = 10
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 clear_req,
  input  wire [4:0]           lg,
  input  wire                 q_empty,
  input  wire rhh_pkg::q_item_t q_item,
  output logic                q_pop,
  output logic                res_valid,
  output rhh_pkg::out_item_t  res,
  output logic                clearing
);

  localparam int MW = MAX_SLOTS_LOG;
  localparam int CW = MW + 1;
  localparam int PW = MW + 2;
  localparam int EW = MW + 65;

  rhh_pkg::back_state_t state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   ck_r, ck_nxt;
  logic [31:0]   cv_r, cv_nxt;
  logic [MW-1:0] cd_r, cd_nxt;
  logic [MW-1:0] i_r, i_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [PW-1:0] probes_r, probes_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [MW-1:0] clr_r, clr_nxt;
  logic          outv_r, outv_nxt;
  rhh_pkg::out_item_t out_r, out_nxt;

  logic          we;
  logic [MW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          e_used;
  logic [MW-1:0] e_dist;
  logic [31:0]   e_key, e_val;
  logic [CW-1:0] tsize;
  logic [MW-1:0] mask, nx, home;
  logic [31:0]   hshift;
  logic          fail, match, keep_going, sh_stop;
  logic [PW+10:0] probes_wide;
  logic [CW+10:0] occ_wide, occ_inc_wide, occ_dec_wide;
  logic [CW-1:0] used_dec;

  rhh_ram #(.WIDTH(EW), .DEPTH(1 << MW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign e_used = rdata[EW-1];
  assign e_dist = rdata[EW-2 -: MW];
  assign e_key  = rdata[63:32];
  assign e_val  = rdata[31:0];

  assign tsize  = CW'(1) << lg;
  assign mask   = MW'(tsize - CW'(1));
  assign nx     = (i_r + MW'(1)) & mask;
  assign hshift = q_item.hash >> (6'd32 - {1'b0, lg});
  assign home   = hshift[MW-1:0];

  assign fail = (q_item.key == 32'd0) || (q_item.kind == rhh_pkg::KIND_NOP) ||
                ((q_item.kind == rhh_pkg::KIND_INSERT) && (used_r >= tsize));
  assign match      = e_used && (e_key == ck_r);
  assign keep_going = (off_r <= {1'b0, e_dist}) && (off_r <= {1'b0, mask});
  assign sh_stop    = ((steps_r + CW'(1)) >= tsize) || !e_used || (e_dist == '0);
  assign used_dec   = (used_r != '0) ? used_r - CW'(1) : used_r;

  assign probes_wide  = {11'd0, probes_r};
  assign occ_wide     = {11'd0, used_r};
  assign occ_inc_wide = {11'd0, used_r + CW'(1)};
  assign occ_dec_wide = {11'd0, used_dec};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhh_pkg::B_CLEAR:   if (clr_r == '1) state_nxt = rhh_pkg::B_IDLE;
      rhh_pkg::B_IDLE:    if (!q_empty && !fail) state_nxt = rhh_pkg::B_RD;
      rhh_pkg::B_RD:      state_nxt = rhh_pkg::B_EVAL;
      rhh_pkg::B_EVAL: begin
        if (kind_r == rhh_pkg::KIND_INSERT) begin
          state_nxt = e_used ? rhh_pkg::B_RD : rhh_pkg::B_IDLE;
        end else if (match) begin
          state_nxt = (kind_r == rhh_pkg::KIND_LOOKUP) ? rhh_pkg::B_IDLE : rhh_pkg::B_SH_RD;
        end else begin
          state_nxt = keep_going ? rhh_pkg::B_RD : rhh_pkg::B_IDLE;
        end
      end
      rhh_pkg::B_SH_RD:   state_nxt = rhh_pkg::B_SH_EVAL;
      rhh_pkg::B_SH_EVAL: state_nxt = sh_stop ? rhh_pkg::B_IDLE : rhh_pkg::B_SH_RD;
      default:            state_nxt = rhh_pkg::B_IDLE;
    endcase
    if (clear_req) state_nxt = rhh_pkg::B_CLEAR;
  end

  always_comb begin
    kind_nxt = kind_r;  ck_nxt = ck_r;  cv_nxt = cv_r;  cd_nxt = cd_r;
    i_nxt = i_r;  off_nxt = off_r;  probes_nxt = probes_r;  steps_nxt = steps_r;
    used_nxt = used_r;  clr_nxt = clr_r;
    outv_nxt = 1'b0;  out_nxt = out_r;
    we = 1'b0;  waddr = i_r;  wdata = '0;  raddr = i_r;  q_pop = 1'b0;
    unique case (state_r)
      rhh_pkg::B_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        clr_nxt = clr_r + MW'(1);
        used_nxt = '0;
      end
      rhh_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          kind_nxt = q_item.kind;  ck_nxt = q_item.key;  cv_nxt = q_item.value;
          cd_nxt = '0;  i_nxt = home;  off_nxt = '0;  probes_nxt = PW'(1);
          steps_nxt = '0;
          if (fail) begin
            outv_nxt = 1'b1;
            out_nxt = '{ok: 1'b0, found_value: 32'd0, probes: 11'd1,
                        occupancy: occ_wide[10:0]};
          end
        end
      end
      rhh_pkg::B_RD: raddr = i_r;
      rhh_pkg::B_EVAL: begin
        if (kind_r == rhh_pkg::KIND_INSERT) begin
          if (!e_used) begin
            we = 1'b1;
            wdata = {1'b1, cd_r, ck_r, cv_r};
            used_nxt = used_r + CW'(1);
            outv_nxt = 1'b1;
            out_nxt = '{ok: 1'b1, found_value: 32'd0, probes: probes_wide[10:0],
                        occupancy: occ_inc_wide[10:0]};
          end else begin
            if (e_dist < cd_r) begin
              we = 1'b1;
              wdata = {1'b1, cd_r, ck_r, cv_r};
              ck_nxt = e_key;
              cv_nxt = e_val;
              cd_nxt = e_dist + MW'(1);
            end else begin
              cd_nxt = cd_r + MW'(1);
            end
            i_nxt = nx;
            probes_nxt = probes_r + PW'(1);
          end
        end else if (match) begin
          if (kind_r == rhh_pkg::KIND_LOOKUP) begin
            outv_nxt = 1'b1;
            out_nxt = '{ok: 1'b1, found_value: e_val, probes: probes_wide[10:0],
                        occupancy: occ_wide[10:0]};
          end
          steps_nxt = '0;
        end else if (keep_going) begin
          i_nxt = nx;
          off_nxt = off_r + CW'(1);
          probes_nxt = probes_r + PW'(1);
        end else begin
          outv_nxt = 1'b1;
          out_nxt = '{ok: 1'b0, found_value: 32'd0, probes: probes_wide[10:0],
                      occupancy: occ_wide[10:0]};
        end
      end
      rhh_pkg::B_SH_RD: raddr = nx;
      rhh_pkg::B_SH_EVAL: begin
        we = 1'b1;
        if (sh_stop) begin
          wdata = '0;
          used_nxt = used_dec;
          outv_nxt = 1'b1;
          out_nxt = '{ok: 1'b1, found_value: 32'd0, probes: probes_wide[10:0],
                      occupancy: occ_dec_wide[10:0]};
        end else begin
          wdata = {1'b1, e_dist - MW'(1), e_key, e_val};
          i_nxt = nx;
          steps_nxt = steps_r + CW'(1);
        end
      end
      default: ;
    endcase
    if (clear_req) clr_nxt = '0;
  end

  assign res_valid = outv_r;
  assign res       = out_r;
  assign clearing  = (state_r == rhh_pkg::B_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhh_pkg::B_CLEAR;
      clr_r   <= '0;
      used_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      outv_r  <= outv_nxt;
    end
    kind_r <= kind_nxt;  ck_r <= ck_nxt;  cv_r <= cv_nxt;  cd_r <= cd_nxt;
    i_r <= i_nxt;  off_r <= off_nxt;  probes_r <= probes_nxt;
    steps_r <= steps_nxt;  out_r <= out_nxt;
  end

endmodule
`default_nettype wire

### sv/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: front end, request queue and back end.
//
// A request transaction (in_data: kind, key, value) is taken at a rising edge
// where start is high and busy is low. The front end trims the key at its
// first zero byte and hashes it with FNV-1a, one byte per cycle, followed by
// one Fibonacci multiply; the hashed request then waits in a two-entry queue.
// The back end walks the probe chain in the slot RAM; each probe step reads
// the RAM in state B_RD and evaluates the entry in B_EVAL, because the RAM
// read is registered. The front end takes a new request only after it has
// pushed the last one into the queue, and the back end takes a new request
// from the queue only once it is back in its idle state, which sets the
// sustained rate. Each result transaction is shown on out_data for exactly
// one cycle with out_valid high; the receiver cannot stall, so results never
// back up. After reset, and after every write to the size register on the
// cfg channel, the back end sweeps the whole RAM, one slot per cycle, and
// busy stays high until the table is empty.
// Configuration is accepted in any cycle (cfg_ready is always high).
`default_nettype none
module robin_hood_hash_table #(
  parameter int MAX_SLOTS_LOG = 10
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire rhh_pkg::in_item_t in_data,
  output logic                out_valid,
  output rhh_pkg::out_item_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [3:0]           cfg_data
);

  logic [3:0] size_r, size_nxt;
  logic [4:0] lg;
  logic       cfg_write;
  logic       accept;
  logic       front_busy, back_clearing;
  logic       q_push, q_pop, q_full, q_empty;
  rhh_pkg::q_item_t push_item, pop_item;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign size_nxt  = cfg_write ? cfg_data : size_r;

  // Clamp the size register to the range the RAM supports.
  always_comb begin
    if (size_r == 4'd0) begin
      lg = 5'd1;
    end else if ({1'b0, size_r} > 5'(MAX_SLOTS_LOG)) begin
      lg = 5'(MAX_SLOTS_LOG);
    end else begin
      lg = {1'b0, size_r};
    end
  end

  // The block is busy while the front end holds a request (hashing it or waiting to push it) or the table is cleared.
  assign busy   = front_busy || back_clearing;
  assign accept = start && !busy;

  rhh_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_item(in_data),
    .q_full(q_full), .q_push(q_push), .q_item(push_item), .busy(front_busy)
  );

  rhh_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(push_item),
    .full(q_full), .pop(q_pop), .pop_item(pop_item), .empty(q_empty)
  );

  rhh_back #(.MAX_SLOTS_LOG(MAX_SLOTS_LOG)) u_back (
    .clk(clk), .rst_n(rst_n), .clear_req(cfg_write), .lg(lg),
    .q_empty(q_empty), .q_item(pop_item), .q_pop(q_pop),
    .res_valid(out_valid), .res(out_data), .clearing(back_clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= rhh_pkg::SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the Robin Hood hash table: directed and random requests against a predictor.
`default_nettype none
module tb_top;

  localparam int SLOTS      = 1024;
  localparam int WATCH_MAX  = 40000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  rhh_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  rhh_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [3:0] cfg_data = '0;

  always #4 clk = ~clk;

  robin_hood_hash_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: a shadow copy of the slot table.
  logic [31:0] tbl_key [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  int          tbl_dist[SLOTS];
  bit          tbl_used[SLOTS];
  int          fill_count;
  int          tbl_log;

  rhh_pkg::in_item_t  pending_reqs[$];
  rhh_pkg::out_item_t expected_results[$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;
  int        gap_left = 0;
  int        quiet_cycles = 0;

  logic [31:0] key_pool[$];

  function automatic void clear_table();
    for (int s = 0; s < SLOTS; s++) begin
      tbl_key[s] = '0;
      tbl_val[s] = '0;
      tbl_dist[s] = 0;
      tbl_used[s] = 1'b0;
    end
    fill_count = 0;
  endfunction

  function automatic int active_log();
    if (tbl_log < 1) return 1;
    if (tbl_log > 10) return 10;
    return tbl_log;
  endfunction

  // Bytes up to the first zero byte make up the key.
  function automatic logic [31:0] trim_key(logic [31:0] raw);
    logic [31:0] k;
    k = '0;
    for (int b = 0; b < rhh_pkg::KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) break;
      k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  function automatic int home_of(logic [31:0] k, int lg);
    logic [31:0] h;
    h = rhh_pkg::FNV_BASIS;
    for (int b = 0; b < rhh_pkg::KEY_BYTES; b++) begin
      if (k[8*b +: 8] == 8'd0) break;
      h = h ^ {24'd0, k[8*b +: 8]};
      h = h * rhh_pkg::FNV_PRIME;
    end
    h = h * rhh_pkg::FIB_MULT;
    return int'(h >> (32 - lg));
  endfunction

  // Works out the response to one request and updates the shadow table.
  function automatic rhh_pkg::out_item_t predict_response(rhh_pkg::in_item_t req);
    rhh_pkg::out_item_t r;
    logic [31:0] k, ck, cv, tk, tv;
    int lg, tsize, mask, i, cd, td, guard, off, hit, j, steps, nx;
    r = '0;
    r.probes = 11'd1;
    k = trim_key(req.key);
    lg = active_log();
    tsize = 1 << lg;
    mask = tsize - 1;
    if (k != 0 && req.kind == rhh_pkg::KIND_INSERT && fill_count < tsize) begin
      i = home_of(k, lg);
      ck = k; cv = req.value; cd = 0; guard = 0;
      forever begin
        if (!tbl_used[i]) begin
          tbl_used[i] = 1'b1;
          tbl_key[i] = ck; tbl_val[i] = cv; tbl_dist[i] = cd;
          break;
        end
        if (tbl_dist[i] < cd) begin
          tk = tbl_key[i]; tv = tbl_val[i]; td = tbl_dist[i];
          tbl_key[i] = ck; tbl_val[i] = cv; tbl_dist[i] = cd;
          ck = tk; cv = tv; cd = td;
        end
        if (guard >= tsize) break;
        guard++;
        i = (i + 1) & mask;
        cd++;
        r.probes = r.probes + 11'd1;
      end
      fill_count++;
      r.ok = 1'b1;
    end else if (k != 0 && (req.kind == rhh_pkg::KIND_LOOKUP ||
                            req.kind == rhh_pkg::KIND_REMOVE)) begin
      i = home_of(k, lg);
      off = 0; guard = 0;
      while (!(tbl_used[i] && tbl_key[i] == k) && off <= tbl_dist[i] && guard <= mask) begin
        r.probes = r.probes + 11'd1;
        i = (i + 1) & mask;
        off++;
        guard++;
      end
      hit = tbl_used[i] && tbl_key[i] == k;
      if (hit) begin
        r.ok = 1'b1;
        j = i & mask;
        if (req.kind == rhh_pkg::KIND_LOOKUP) begin
          r.found_value = tbl_val[j];
        end else begin
          // Backward shift: pull later entries one slot towards home.
          steps = 0;
          forever begin
            nx = (j + 1) & mask;
            if (steps + 1 >= tsize || !tbl_used[nx] || tbl_dist[nx] == 0) break;
            tbl_key[j] = tbl_key[nx];
            tbl_val[j] = tbl_val[nx];
            tbl_dist[j] = tbl_dist[nx] - 1;
            j = nx;
            steps++;
          end
          tbl_used[j] = 1'b0;
          tbl_dist[j] = 0;
          if (fill_count > 0) fill_count--;
        end
      end
    end
    r.occupancy = 11'(fill_count);
    return r;
  endfunction

  // Driver: a request transaction completes at an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(predict_response(in_data));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 && !no_idle && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 14);
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        rhh_pkg::out_item_t want;
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction of any kind.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_MAX) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void build_pool(int n);
    logic [31:0] k;
    int len;
    key_pool.delete();
    for (int p = 0; p < n; p++) begin
      len = $urandom_range(1, 4);
      k = '0;
      for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
      key_pool.push_back(k);
    end
  endfunction

  // Pool key with random bytes hidden behind its terminating zero byte.
  function automatic logic [31:0] raw_from_pool();
    logic [31:0] k;
    int len;
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    len = 4;
    for (int b = 3; b >= 0; b--) if (k[8*b +: 8] == 8'd0) len = b;
    for (int b = len + 1; b < 4; b++) k[8*b +: 8] = 8'($urandom);
    return k;
  endfunction

  function automatic void queue_random(int count);
    rhh_pkg::in_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) it.kind = rhh_pkg::KIND_INSERT;
      else if (pick < 70) it.kind = rhh_pkg::KIND_LOOKUP;
      else if (pick < 95) it.kind = rhh_pkg::KIND_REMOVE;
      else it.kind = rhh_pkg::KIND_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 85) it.key = raw_from_pool();
      else if (pick < 96) it.key = $urandom;
      else it.key = {24'($urandom_range(0, 32'h00ffffff)), 8'd0};
      it.value = $urandom;
      pending_reqs.push_back(it);
    end
  endfunction

  function automatic rhh_pkg::in_item_t mk(logic [1:0] kd, logic [31:0] ky, logic [31:0] vl);
    rhh_pkg::in_item_t it;
    it.kind = kd; it.key = ky; it.value = vl;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] lg);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lg;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    tbl_log = int'(lg);
    clear_table();
  endtask

  logic [3:0] phase_size[9]  = '{4'd1, 4'd2, 4'd0, 4'd15, 4'd3, 4'd5, 4'd4, 4'd7, 4'd10};
  int         phase_items[9] = '{70, 100, 60, 300, 150, 300, 200, 200, 450};

  initial begin
    int slots;
    tbl_log = int'(rhh_pkg::SIZE_RESET);
    clear_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the full-size table straight after reset.
    pending_reqs.push_back(mk(rhh_pkg::KIND_INSERT, 32'h0000_0000, 32'h1111_1111));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'h1234_5600, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'hffff_ff00, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_NOP,    32'h0000_0041, 32'hdead_beef));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_INSERT, 32'h0000_0041, 32'hffff_ffff));
    pending_reqs.push_back(mk(rhh_pkg::KIND_INSERT, 32'hffff_ffff, 32'h0000_0000));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'hab00_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_INSERT, 32'h5500_0041, 32'h0000_0002));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_NOP,    32'h0000_0000, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'h0000_0041, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_INSERT, 32'h0102_0304, 32'h8000_0001));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'h0102_0304, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_REMOVE, 32'hffff_ffff, 32'h0));
    pending_reqs.push_back(mk(rhh_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'h0));
    wait_drained();

    // Each phase resizes (and so empties) the table, then runs random traffic.
    for (int ph = 0; ph < 9; ph++) begin
      write_size(phase_size[ph]);
      slots = 1 << active_log();
      build_pool((slots + 4 > 48) ? 48 : slots + 4);
      if (ph == 8) begin
        queue_random(phase_items[ph] - 150);
        while (pending_reqs.size() > 0) @(posedge clk);
        no_idle = 1'b1;
        queue_random(150);
      end else begin
        queue_random(phase_items[ph]);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
